>>> rtl/core/mtc_pkg.sv
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types, character codes and Morse tables for the text codec.
// ----------------------------------------------------------------------------
`default_nettype none
package mtc_pkg;

	localparam int MAX_SYM    = 5;
	localparam int SYM_LEN_W  = $clog2(MAX_SYM + 1);
	localparam int SYM_IDX_W  = $clog2(MAX_SYM);
	localparam int CODE_COUNT = 36;
	localparam int CODE_IDX_W = 6;
	localparam int CODE_BIT_W = 5;
	localparam int CODE_LEN_W = 3;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	localparam logic [CODE_IDX_W-1:0] IDX_DIGIT1 = 6'd26;
	localparam logic [CODE_IDX_W-1:0] IDX_ZERO   = 6'd35;

	// element i of a code is bit i, dash is 1
	localparam logic [CODE_LEN_W-1:0] CODE_LEN [CODE_COUNT] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
		3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
		3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
	};

	localparam logic [CODE_BIT_W-1:0] CODE_BITS [CODE_COUNT] = '{
		5'd2,  5'd1,  5'd5,  5'd1,  5'd0,  5'd4,  5'd3,  5'd0,  5'd0,  5'd14,
		5'd5,  5'd2,  5'd3,  5'd1,  5'd7,  5'd6,  5'd11, 5'd2,  5'd0,  5'd1,
		5'd4,  5'd8,  5'd6,  5'd9,  5'd13, 5'd3,
		5'd30, 5'd28, 5'd24, 5'd16, 5'd0,  5'd1,  5'd3,  5'd7,  5'd15, 5'd31
	};

	typedef struct packed {
		logic                 pre_space;
		logic [SYM_LEN_W-1:0] elem_len;
		logic [MAX_SYM-1:0]   elem_bits;
		logic [7:0]           chr;
	} job_t;

	function automatic logic [7:0] code_chr(input logic [CODE_IDX_W-1:0] k);
		logic [7:0] r;
		if (k < IDX_DIGIT1) begin
			r = CH_A + 8'(k);
		end else if (k < IDX_ZERO) begin
			r = CH_1 + 8'(k - IDX_DIGIT1);
		end else begin
			r = CH_0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/mtc_front.sv
// ----------------------------------------------------------------------------
// mtc_front
// Takes input bytes, tracks decode state and queues output jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module mtc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic          cfg_wdata,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [7:0]    s_tdata,
	input  wire logic          q_full,
	output logic               q_push,
	output mtc_pkg::job_t      q_job
);
	import mtc_pkg::*;

	logic                 mode_q;
	logic [MAX_SYM-1:0]   sym_bits_q;
	logic [SYM_LEN_W-1:0] sym_len_q;
	logic                 sym_inv_q;
	logic                 space_seen_q;
	logic                 word_space_q;

	logic                  accept;
	logic [7:0]            up;
	logic                  enc_hit;
	logic [CODE_IDX_W-1:0] enc_idx;
	logic                  dec_hit;
	logic [CODE_IDX_W-1:0] dec_idx;
	logic                  job_valid;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// encode side: fold case and find the code index
	always_comb begin
		up      = s_tdata;
		enc_hit = 1'b0;
		enc_idx = '0;
		if (s_tdata >= CH_LA && s_tdata <= CH_LZ) begin
			up = s_tdata - CASE_OFS;
		end
		if (up >= CH_A && up <= CH_Z) begin
			enc_hit = 1'b1;
			enc_idx = CODE_IDX_W'(up - CH_A);
		end else if (up >= CH_1 && up <= CH_9) begin
			enc_hit = 1'b1;
			enc_idx = CODE_IDX_W'(up - CH_1) + IDX_DIGIT1;
		end else if (up == CH_0) begin
			enc_hit = 1'b1;
			enc_idx = IDX_ZERO;
		end
	end

	// decode side: match the collected symbol against the table
	always_comb begin
		dec_hit = 1'b0;
		dec_idx = '0;
		for (int k = 0; k < CODE_COUNT; k++) begin
			if (!dec_hit && SYM_LEN_W'(CODE_LEN[k]) == sym_len_q
			    && MAX_SYM'(CODE_BITS[k]) == sym_bits_q) begin
				dec_hit = 1'b1;
				dec_idx = CODE_IDX_W'(k);
			end
		end
		if (sym_inv_q) begin
			dec_hit = 1'b0;
		end
	end

	always_comb begin
		job_valid       = 1'b0;
		q_job.pre_space = 1'b0;
		q_job.elem_len  = '0;
		q_job.elem_bits = '0;
		q_job.chr       = CH_SPACE;
		if (!mode_q) begin
			if (enc_hit) begin
				job_valid       = 1'b1;
				q_job.elem_len  = SYM_LEN_W'(CODE_LEN[enc_idx]);
				q_job.elem_bits = MAX_SYM'(CODE_BITS[enc_idx]);
			end else if (up == CH_SPACE || up == CH_NL) begin
				job_valid = 1'b1;
				q_job.chr = up;
			end
		end else if (s_tdata == CH_SPACE) begin
			if (!space_seen_q && sym_len_q != '0 && dec_hit) begin
				job_valid       = 1'b1;
				q_job.pre_space = word_space_q;
				q_job.chr       = code_chr(dec_idx);
			end
		end else if (s_tdata == CH_NL) begin
			if (sym_len_q == '0) begin
				job_valid = 1'b1;
				q_job.chr = CH_NL;
			end
		end
	end

	assign q_push = accept && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			sym_bits_q   <= '0;
			sym_len_q    <= '0;
			sym_inv_q    <= 1'b0;
			space_seen_q <= 1'b0;
			word_space_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (accept && mode_q) begin
				if (s_tdata == CH_SPACE) begin
					if (!space_seen_q) begin
						space_seen_q <= 1'b1;
						if (job_valid) begin
							word_space_q <= 1'b0;
						end
						sym_bits_q <= '0;
						sym_len_q  <= '0;
						sym_inv_q  <= 1'b0;
					end else begin
						space_seen_q <= 1'b0;
						word_space_q <= 1'b1;
					end
				end else if (s_tdata == CH_NL) begin
					sym_bits_q <= '0;
					sym_len_q  <= '0;
					sym_inv_q  <= 1'b0;
				end else begin
					space_seen_q <= 1'b0;
					if (sym_len_q >= SYM_LEN_W'(MAX_SYM)) begin
						sym_inv_q <= 1'b1;
					end else begin
						if (s_tdata == CH_DASH) begin
							sym_bits_q[sym_len_q[SYM_IDX_W-1:0]] <= 1'b1;
						end else if (s_tdata != CH_DOT) begin
							sym_inv_q <= 1'b1;
						end
						sym_len_q <= sym_len_q + 1'b1;
					end
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sym_len_q <= SYM_LEN_W'(MAX_SYM))
		else $error("symbol length beyond limit");
	a_empty_sym: assert property (@(posedge clk) disable iff (!arst_n)
		sym_len_q == '0 |-> (sym_bits_q == '0 && !sym_inv_q))
		else $error("empty symbol carries stale data");
`endif

endmodule
`default_nettype wire

>>> rtl/core/mtc_queue.sv
// ----------------------------------------------------------------------------
// mtc_queue
// Small job queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module mtc_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mtc_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output mtc_pkg::job_t      pop_job,
	output logic               empty
);
	import mtc_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = cnt_q == QCNT_W'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");
	a_pop_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count did not drop on pop");
`endif

endmodule
`default_nettype wire

>>> rtl/core/mtc_back.sv
// ----------------------------------------------------------------------------
// mtc_back
// Plays one job out as a run of output bytes, last byte flagged.
// ----------------------------------------------------------------------------
`default_nettype none
module mtc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mtc_pkg::job_t q_job,
	input  wire logic          q_empty,
	output logic               q_pop,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [7:0]         m_tdata,
	output logic               m_tlast
);
	import mtc_pkg::*;

	logic active_q;
	job_t cur_q;
	logic take;

	always_comb begin
		if (cur_q.pre_space) begin
			m_tdata = CH_SPACE;
		end else if (cur_q.elem_len != '0) begin
			m_tdata = cur_q.elem_bits[0] ? CH_DASH : CH_DOT;
		end else begin
			m_tdata = cur_q.chr;
		end
	end

	assign m_tvalid = active_q;
	assign m_tlast  = !cur_q.pre_space && cur_q.elem_len == '0;
	assign take     = active_q && m_tready;
	assign q_pop    = !q_empty && (!active_q || (m_tready && m_tlast));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (q_pop) begin
			active_q <= 1'b1;
		end else if (take && m_tlast) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_job;
		end else if (take) begin
			if (cur_q.pre_space) begin
				cur_q.pre_space <= 1'b0;
			end else if (cur_q.elem_len != '0) begin
				cur_q.elem_len  <= cur_q.elem_len - 1'b1;
				cur_q.elem_bits <= cur_q.elem_bits >> 1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("run ended without last");
	a_elem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> cur_q.elem_len <= SYM_LEN_W'(MAX_SYM))
		else $error("element count beyond limit");
`endif

endmodule
`default_nettype wire

>>> rtl/core/morse_text_codec_core.sv
// ----------------------------------------------------------------------------
// morse_text_codec_core
// ASCII to International Morse encoder and Morse to ASCII decoder.
// ----------------------------------------------------------------------------
// channel  | dir | data               | side
// s_*      | in  | tdata: in_char     | input bytes
// m_*      | out | tdata: out_char    | output bytes, tlast marks last per request
// cfg_*    | in  | wdata: mode        | 0 encode, 1 decode
//
// one input byte is taken per cycle while the four-entry job queue has room
// the output side sends one byte per cycle while m_tready is high; an input byte gives 1 to 6 output bytes
// input bytes that produce nothing push no job into the queue
// arst_n clears mode, the decode state and the queue
// either side may stall alone; the queue absorbs the difference
// ----------------------------------------------------------------------------
`default_nettype none
module morse_text_codec_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_char
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_char
	output logic            m_tlast
);
	import mtc_pkg::*;

	job_t push_job;
	job_t pop_job;
	logic push;
	logic pop;
	logic full;
	logic empty;

	mtc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (full),
		.q_push    (push),
		.q_job     (push_job)
	);

	mtc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	mtc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_job    (pop_job),
		.q_empty  (empty),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire
